>>> design/gsue_pkg.sv
`timescale 1ns / 1ps

package gsue_pkg;

    // action codes of an input transaction
    typedef enum logic [1:0] {
        ACT_REQUEST = 2'd0,
        ACT_TX_SLOT = 2'd1,
        ACT_RX_BYTE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // status codes of a result transaction
    typedef enum logic [3:0] {
        ST_REQ_ACCEPTED = 4'd0,
        ST_REQ_BUSY     = 4'd1,
        ST_TX_BYTE      = 4'd2,
        ST_CMD_SENT     = 4'd3,
        ST_BYTE_TAKEN   = 4'd4,
        ST_READING_OK   = 4'd5,
        ST_BAD_HEADER   = 4'd6,
        ST_BAD_CHECKSUM = 4'd7,
        ST_IGNORED      = 4'd8
    } status_t;

    // exchange phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_SEND = 3'b010,
        PH_RECV = 3'b100
    } phase_t;

    localparam int unsigned CMD_LEN = 9;
    localparam logic [7:0] HEADER_BYTE = 8'hFF;

    typedef logic [7:0] cmd_table_t [CMD_LEN];

    // fixed read command sent to the sensor
    localparam cmd_table_t READ_CMD = '{
        8'hFF, 8'h01, 8'h86, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h79
    };

endpackage

>>> design/gas_sensor_uart_exchange_unit.sv
`timescale 1ns / 1ps

// channel  | signals                                   | moves
// ---------+-------------------------------------------+----------------------------
// in       | in_valid, in_ready, action, data_byte     | one event per transaction
// out      | out_valid, out_ready, status, tx_byte,    | one result per input
//          | concentration                             | transaction
//
// every input transaction is handled in the cycle it is accepted; its result
// sits in the output register from the next cycle on
// sustained rate is one transaction per cycle while out_ready stays high, set by the single output register
// in_ready stays high while the output register is empty or is being drained,
// so a stalled consumer holds at most one result and stops the input after it
// rst_n clears the exchange state, the stored reading and the output valid
module gas_sensor_uart_exchange_unit #(
    parameter int unsigned FRAME_LENGTH = 9
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             action,
    input  logic [7:0]             data_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [3:0]             status,
    output logic [7:0]             tx_byte,
    output logic [15:0]            concentration
);
    import gsue_pkg::*;

    localparam logic [3:0] FRAME_LEN_C = 4'(FRAME_LENGTH);
    localparam logic [3:0] CMD_LEN_C   = 4'(CMD_LEN);

    // exchange state
    phase_t      phase_reg, phase_next;
    logic        pending_reg, pending_next;
    logic [3:0]  tx_pos_reg, tx_pos_next;
    logic [3:0]  rx_pos_reg, rx_pos_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] buf_reg, buf_next;
    logic [15:0] reading_reg, reading_next;

    // output register
    logic        out_valid_reg;
    status_t     status_reg, status_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic [15:0] conc_reg;

    logic        in_fire;
    logic [3:0]  rx_pos_inc;
    logic [7:0]  want_sum;

    // the output slot frees up either empty or being taken this cycle
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign rx_pos_inc = rx_pos_reg + 4'd1;
    assign want_sum  = 8'h00 - sum_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        tx_pos_next  = tx_pos_reg;
        rx_pos_next  = rx_pos_reg;
        sum_next     = sum_reg;
        buf_next     = buf_reg;
        reading_next = reading_reg;
        status_next  = ST_IGNORED;
        tx_byte_next = 8'h00;

        case (action_t'(action))
            ACT_REQUEST:
            begin
                // a request always restarts the exchange but keeps the command position, busy only changes status
                status_next  = pending_reg ? ST_REQ_BUSY : ST_REQ_ACCEPTED;
                pending_next = 1'b1;
                rx_pos_next  = 4'd0;
                sum_next     = 8'h00;
                phase_next   = PH_SEND;
            end
            ACT_TX_SLOT:
            begin
                if (phase_reg == PH_SEND)
                begin
                    if (tx_pos_reg >= CMD_LEN_C)
                    begin
                        tx_pos_next = 4'd0;
                        phase_next  = PH_RECV;
                        status_next = ST_CMD_SENT;
                    end
                    else
                    begin
                        tx_byte_next = READ_CMD[tx_pos_reg];
                        tx_pos_next  = tx_pos_reg + 4'd1;
                        status_next  = ST_TX_BYTE;
                    end
                end
            end
            ACT_RX_BYTE:
            begin
                if (phase_reg == PH_RECV && rx_pos_reg < FRAME_LEN_C)
                begin
                    rx_pos_next = rx_pos_inc;
                    if (rx_pos_inc == 4'd1)
                    begin
                        if (data_byte != HEADER_BYTE)
                        begin
                            pending_next = 1'b0;
                            phase_next   = PH_IDLE;
                            status_next  = ST_BAD_HEADER;
                        end
                        else
                        begin
                            status_next = ST_BYTE_TAKEN;
                        end
                    end
                    else if (rx_pos_inc < FRAME_LEN_C)
                    begin
                        // reading is high byte times 256 plus low byte
                        if (rx_pos_inc == 4'd3)
                        begin
                            buf_next = {data_byte, 8'h00};
                        end
                        else if (rx_pos_inc == 4'd4)
                        begin
                            buf_next = buf_reg + {8'h00, data_byte};
                        end
                        sum_next    = sum_reg + data_byte;
                        status_next = ST_BYTE_TAKEN;
                    end
                    else
                    begin
                        // last byte carries the two's complement of the sum
                        if (want_sum == data_byte)
                        begin
                            reading_next = buf_reg;
                            status_next  = ST_READING_OK;
                        end
                        else
                        begin
                            status_next = ST_BAD_CHECKSUM;
                        end
                        pending_next = 1'b0;
                        phase_next   = PH_IDLE;
                    end
                end
            end
            default:
            begin
                status_next = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pending_reg   <= 1'b0;
            tx_pos_reg    <= 4'd0;
            rx_pos_reg    <= 4'd0;
            sum_reg       <= 8'h00;
            buf_reg       <= 16'h0000;
            reading_reg   <= 16'h0000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg     <= phase_next;
                pending_reg   <= pending_next;
                tx_pos_reg    <= tx_pos_next;
                rx_pos_reg    <= rx_pos_next;
                sum_reg       <= sum_next;
                buf_reg       <= buf_next;
                reading_reg   <= reading_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded only with a new transaction
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg  <= status_next;
            tx_byte_reg <= tx_byte_next;
            conc_reg    <= reading_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign tx_byte       = tx_byte_reg;
    assign concentration = conc_reg;

    // an active exchange always has pending set
    a_phase_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> pending_reg)
        else $error("exchange active without pending flag");

    a_tx_range: assert property (@(posedge clk) disable iff (!rst_n)
        tx_pos_reg <= CMD_LEN_C)
        else $error("command position past end");

    a_rx_range: assert property (@(posedge clk) disable iff (!rst_n)
        rx_pos_reg <= FRAME_LEN_C)
        else $error("receive position past frame");

    // every accepted transaction leaves a result behind
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted transaction produced no result");

    // the shown reading only moves with a new result
    a_conc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(conc_reg))
        else $error("reading changed while result stalled");

endmodule

>>> test/tb_gas_sensor_uart_exchange_unit.sv
`timescale 1ns / 1ps

module tb_gas_sensor_uart_exchange_unit;

    import gsue_pkg::*;

    // bench geometry
    localparam int unsigned FRAME_LEN        = 9;
    localparam int unsigned CLK_HALF         = 10;
    localparam int unsigned RESET_CYCLES     = 11;
    localparam int unsigned MAX_WAIT         = 19;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_ITEMS     = 650;
    localparam int unsigned END_DRAIN        = 8;
    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int unsigned DIR_ROWS         = 25;

    // one result transaction as seen on the output ports
    typedef struct packed {
        status_t     status;
        logic [7:0]  tx_byte;
        logic [15:0] conc;
    } result_t;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct packed {
        action_t     act;
        logic [7:0]  data;
        logic        typed;
        status_t     status;
        logic [7:0]  tx_byte;
        logic [15:0] conc;
    } dir_row_t;

    // directed walk: ignored actions while idle, request and busy request,
    // the whole command, end of command, a good frame reading all ones,
    // then a byte arriving after the exchange has closed
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{ACT_NONE,    8'hA5, 1'b1, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_TX_SLOT, 8'h5A, 1'b1, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_RX_BYTE, 8'hFF, 1'b1, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_REQUEST, 8'h00, 1'b1, ST_REQ_ACCEPTED, 8'h00, 16'h0000},
        '{ACT_REQUEST, 8'hFF, 1'b1, ST_REQ_BUSY,     8'h00, 16'h0000},
        '{ACT_TX_SLOT, 8'h00, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_TX_SLOT, 8'hFF, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_TX_SLOT, 8'h00, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_TX_SLOT, 8'hFF, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_TX_SLOT, 8'h00, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_TX_SLOT, 8'hFF, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_TX_SLOT, 8'h00, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_TX_SLOT, 8'hFF, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_TX_SLOT, 8'h00, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_TX_SLOT, 8'hFF, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_RX_BYTE, 8'hFF, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_RX_BYTE, 8'h01, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_RX_BYTE, 8'hFF, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_RX_BYTE, 8'hFF, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_RX_BYTE, 8'h00, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_RX_BYTE, 8'h00, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_RX_BYTE, 8'h00, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_RX_BYTE, 8'h00, 1'b0, ST_IGNORED,      8'h00, 16'h0000},
        '{ACT_RX_BYTE, 8'h01, 1'b1, ST_READING_OK,   8'h00, 16'hFFFF},
        '{ACT_RX_BYTE, 8'h00, 1'b1, ST_IGNORED,      8'h00, 16'hFFFF}
    };

    // dut ports, all inputs known from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [1:0]  action    = ACT_NONE;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  status;
    logic [7:0]  tx_byte;
    logic [15:0] concentration;

    // expected result transactions, oldest first
    result_t expected_results [$];

    // shadow of the exchange state
    phase_t      sh_phase;
    logic        sh_pending;
    logic [3:0]  sh_tx_pos;
    logic [3:0]  sh_rx_pos;
    logic [7:0]  sh_sum;
    logic [15:0] sh_buffer;
    logic [15:0] sh_reading;

    // run control shared between processes
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int unsigned live_items  = 0;
    bit          burst_mode  = 1'b0;
    bit          hold_request = 1'b0;

    gas_sensor_uart_exchange_unit #(
        .FRAME_LENGTH (FRAME_LEN)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .tx_byte       (tx_byte),
        .concentration (concentration)
    );

    always #CLK_HALF clk = ~clk;

    // predicts the result of one transaction and advances the shadow state
    function automatic result_t predict_exchange(input action_t act, input logic [7:0] d);
        result_t r;
        r.status  = ST_IGNORED;
        r.tx_byte = 8'h00;
        case (act)
            ACT_REQUEST:
            begin
                // a request always restarts; the command position survives
                r.status   = sh_pending ? ST_REQ_BUSY : ST_REQ_ACCEPTED;
                sh_pending = 1'b1;
                sh_rx_pos  = 4'd0;
                sh_sum     = 8'h00;
                sh_phase   = PH_SEND;
            end
            ACT_TX_SLOT:
            begin
                if (sh_phase == PH_SEND)
                begin
                    if (sh_tx_pos >= CMD_LEN)
                    begin
                        sh_tx_pos = 4'd0;
                        sh_phase  = PH_RECV;
                        r.status  = ST_CMD_SENT;
                    end
                    else
                    begin
                        r.tx_byte = READ_CMD[sh_tx_pos];
                        sh_tx_pos = sh_tx_pos + 4'd1;
                        r.status  = ST_TX_BYTE;
                    end
                end
            end
            ACT_RX_BYTE:
            begin
                if (sh_phase == PH_RECV && sh_rx_pos < FRAME_LEN)
                begin
                    sh_rx_pos = sh_rx_pos + 4'd1;
                    if (sh_rx_pos == 4'd1)
                    begin
                        if (d != HEADER_BYTE)
                        begin
                            sh_pending = 1'b0;
                            sh_phase   = PH_IDLE;
                            r.status   = ST_BAD_HEADER;
                        end
                        else
                            r.status = ST_BYTE_TAKEN;
                    end
                    else if (sh_rx_pos < FRAME_LEN)
                    begin
                        // reading is the third byte high, fourth byte low
                        if (sh_rx_pos == 4'd3)
                            sh_buffer = {d, 8'h00};
                        else if (sh_rx_pos == 4'd4)
                            sh_buffer = sh_buffer + {8'h00, d};
                        sh_sum   = sh_sum + d;
                        r.status = ST_BYTE_TAKEN;
                    end
                    else
                    begin
                        // closing byte is the two's complement of the sum
                        if (d == 8'h00 - sh_sum)
                        begin
                            sh_reading = sh_buffer;
                            r.status   = ST_READING_OK;
                        end
                        else
                            r.status = ST_BAD_CHECKSUM;
                        sh_pending = 1'b0;
                        sh_phase   = PH_IDLE;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.conc = sh_reading;
        return r;
    endfunction

    // idle cycles before the next transaction on either side
    function automatic int unsigned draw_wait();
        return burst_mode ? 0 : $urandom_range(MAX_WAIT, 0);
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d at cycle %0d",
                 field, got, want, cycle_count);
        mismatches++;
    endtask

    // offers one input transaction and returns right after it is accepted;
    // valid stays high on return so back-to-back offers never drop it
    task automatic send_item(input action_t act, input logic [7:0] d,
                             input logic use_typed, input result_t typed);
        int unsigned gap;
        result_t     predicted;
        gap = draw_wait();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        predicted = predict_exchange(act, d);
        expected_results.push_back(use_typed ? typed : predicted);
        if (predicted.status != ST_IGNORED)
            live_items++;
        action    <= act;
        data_byte <= d;
        in_valid  <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    // one random exchange: mostly well-formed with random content, sometimes
    // broken by noise, a bad header, a bad checksum or a request mid-frame
    task automatic run_exchange();
        logic [7:0]  frame [FRAME_LEN];
        logic [7:0]  sum;
        int unsigned k;
        bit          cut;
        int unsigned cut_at;
        sum = 8'h00;
        if ($urandom_range(3, 0) == 0)
            send_item(ACT_NONE, 8'($urandom), 1'b0, '0);
        if ($urandom_range(5, 0) == 0)
            send_item(ACT_TX_SLOT, 8'($urandom), 1'b0, '0);
        send_item(ACT_REQUEST, 8'($urandom), 1'b0, '0);
        if ($urandom_range(7, 0) == 0)
            send_item(ACT_REQUEST, 8'($urandom), 1'b0, '0);

        // walk the command out, with stray transactions mixed in
        while (sh_phase == PH_SEND)
        begin
            case ($urandom_range(23, 0))
                0:       send_item(ACT_RX_BYTE, 8'($urandom), 1'b0, '0);
                1:       send_item(ACT_NONE, 8'($urandom), 1'b0, '0);
                2:       send_item(ACT_REQUEST, 8'($urandom), 1'b0, '0);
                default: send_item(ACT_TX_SLOT, 8'($urandom), 1'b0, '0);
            endcase
        end

        // build the sensor reply
        frame[0] = 8'($urandom);
        if ($urandom_range(9, 0) != 0)
            frame[0] = HEADER_BYTE;
        for (k = 1; k < FRAME_LEN; k++)
            frame[k] = 8'($urandom);
        case ($urandom_range(7, 0))
            0:
            begin
                frame[2] = 8'h00;
                frame[3] = 8'h00;
            end
            1:
            begin
                frame[2] = 8'hFF;
                frame[3] = 8'hFF;
            end
            default:
            begin
            end
        endcase
        for (k = 1; k < FRAME_LEN - 1; k++)
            sum = sum + frame[k];
        frame[FRAME_LEN - 1] = 8'h00 - sum;
        if ($urandom_range(7, 0) == 0)
            frame[FRAME_LEN - 1] = frame[FRAME_LEN - 1] ^ 8'($urandom_range(255, 1));
        cut    = ($urandom_range(11, 0) == 0);
        cut_at = $urandom_range(FRAME_LEN - 1, 1);

        k = 0;
        while (sh_phase == PH_RECV && k < FRAME_LEN)
        begin
            if (cut && k == cut_at)
                send_item(ACT_REQUEST, 8'($urandom), 1'b0, '0);
            else if ($urandom_range(19, 0) == 0)
                send_item($urandom_range(1, 0) ? ACT_TX_SLOT : ACT_NONE,
                          8'($urandom), 1'b0, '0);
            else
            begin
                send_item(ACT_RX_BYTE, frame[k], 1'b0, '0);
                k++;
            end
        end
    endtask

    // sender: reset, directed table, then random exchanges
    initial
    begin : stimulus
        int unsigned row;
        int unsigned exchange_no;
        sh_phase    = PH_IDLE;
        sh_pending  = 1'b0;
        sh_tx_pos   = 4'd0;
        sh_rx_pos   = 4'd0;
        sh_sum      = 8'h00;
        sh_buffer   = 16'h0000;
        sh_reading  = 16'h0000;
        exchange_no = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIR_ROWS; row++)
            send_item(DIRECTED[row].act, DIRECTED[row].data, DIRECTED[row].typed,
                      '{DIRECTED[row].status, DIRECTED[row].tx_byte, DIRECTED[row].conc});

        live_items = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            // every seventh exchange runs with no idling on either side
            burst_mode = (exchange_no % 7 == 3);
            // long receiver hold-off while the sender keeps offering
            if (exchange_no == 4 || exchange_no == 18)
                hold_request = 1'b1;
            // sender pause until every outstanding result has come back
            if (exchange_no == 10 || exchange_no == 24)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while (expected_results.size() != 0);
            end
            run_exchange();
            exchange_no++;
        end
        burst_mode = 1'b0;

        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
        repeat (END_DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("gas_sensor_uart_exchange_unit regression: pass");
        else
            $display("gas_sensor_uart_exchange_unit regression: fail");
        $finish;
    end

    // receiver: random stall per result, occasional long hold-off
    initial
    begin : receiver
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            stall = draw_wait();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // checker: every accepted result against the oldest expectation
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing outstanding", int'(status), -1);
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", int'(status), int'(want.status));
                if (tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", int'(tx_byte), int'(want.tx_byte));
                if (concentration !== want.conc)
                    report_mismatch("concentration", int'(concentration), int'(want.conc));
            end
        end
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("gas_sensor_uart_exchange_unit regression: fail");
            $finish;
        end
    end

endmodule

>>> files.f
design/gsue_pkg.sv
design/gas_sensor_uart_exchange_unit.sv
test/tb_gas_sensor_uart_exchange_unit.sv
